// ----- design/tmqe_pkg.sv -----
// Package for the typed message queue engine: sizes, status and opcode
// constants, and the structs passed between the top level and its cells.
// No dependencies.
package tmqe_pkg;

  localparam int QUEUE_COUNT      = 16;
  localparam int SLOTS_PER_QUEUE  = 16;
  localparam int ATTACH_PER_QUEUE = 8;
  localparam int MAX_MSG_BYTES    = 128;

  localparam int QIW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SIW   = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int AIW   = (ATTACH_PER_QUEUE > 1) ? $clog2(ATTACH_PER_QUEUE) : 1;
  localparam int CNT_W = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int UC_W  = $clog2(ATTACH_PER_QUEUE + 1);

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_QUEUE    = 3'd1;
  localparam logic [2:0] ST_ATTACH_STATE = 3'd2;
  localparam logic [2:0] ST_CREATE_RULE  = 3'd3;
  localparam logic [2:0] ST_WOULD_BLOCK  = 3'd4;
  localparam logic [2:0] ST_REFUSED      = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd6;

  localparam logic [1:0] OP_ATTACH  = 2'd0;
  localparam logic [1:0] OP_DETACH  = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;
  localparam logic [1:0] OP_RECEIVE = 2'd3;

  localparam logic REG_MAX_BYTES = 1'b0;
  localparam logic REG_MAX_MSGS  = 1'b1;

  localparam logic [11:0] MAX_BYTES_RST = 12'd2048;
  localparam logic [4:0]  MAX_MSGS_RST  = 5'd16;

  typedef struct packed {
    logic [30:0] mtype;
    logic [7:0]  size;
    logic [63:0] body;
  } slot_data_t;

  typedef struct packed {
    logic wr_new;
    logic wr_shift;
  } slot_ctrl_t;

  typedef struct packed {
    logic set;
    logic clr;
  } att_ctrl_t;

  typedef struct packed {
    logic eq;
    logic free;
  } att_stat_t;

endpackage

// ----- design/tmqe_slot_cell.sv -----
// One slot position of every queue: holds that position's message for each
// queue, takes a new message on a send, matches it against the receive selector
// and takes its neighbor's message when a removal closes the gap. Depends on tmqe_pkg.
module tmqe_slot_cell (
  input  logic                    clk,
  input  logic [tmqe_pkg::QIW-1:0] qidx,
  input  tmqe_pkg::slot_ctrl_t    ctrl,
  input  tmqe_pkg::slot_data_t    new_data,
  input  tmqe_pkg::slot_data_t    nbr_data,
  input  logic [31:0]             sel,
  output tmqe_pkg::slot_data_t    cur,
  output logic                    match
);
  import tmqe_pkg::*;

  slot_data_t  store [QUEUE_COUNT];
  logic [31:0] mag;
  logic [31:0] t32;

  always_ff @(posedge clk) begin
    if (ctrl.wr_new) begin
      store[qidx] <= new_data;
    end else if (ctrl.wr_shift) begin
      store[qidx] <= nbr_data;
    end
  end

  assign cur   = store[qidx];
  assign mag   = ~sel + 32'd1;
  assign t32   = {1'b0, cur.mtype};
  assign match = (sel == 32'd0) || (!sel[31] && (t32 == sel)) || (sel[31] && (t32 <= mag));

endmodule

// ----- design/tmqe_att_cell.sv -----
// One attach entry position of every queue: valid bit and requester id per
// queue, with match and free flags for the addressed queue.
// Depends on tmqe_pkg.
module tmqe_att_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [tmqe_pkg::QIW-1:0] qidx,
  input  logic [15:0]             rid,
  input  tmqe_pkg::att_ctrl_t     ctrl,
  output tmqe_pkg::att_stat_t     stat
);
  import tmqe_pkg::*;

  logic        valid [QUEUE_COUNT];
  logic [15:0] id    [QUEUE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (ctrl.set) begin
      valid[qidx] <= 1'b1;
    end else if (ctrl.clr) begin
      valid[qidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set) begin
      id[qidx] <= rid;
    end
  end

  assign stat.eq   = valid[qidx] && (id[qidx] == rid);
  assign stat.free = !valid[qidx];

endmodule

// ----- design/typed_message_queue_engine.sv -----
// Top level of the typed message queue engine: command port, APB registers,
// control sequencer, and the rows of attach and slot cells.
// Depends on tmqe_pkg, tmqe_att_cell and tmqe_slot_cell.

// A request is taken when start is high and busy is low. A bad queue id is
// answered in the next cycle. Otherwise the sequencer walks the queue's
// attach entries one per cycle and then executes: attach, detach and send
// finish in the execute step, and so does a receive that is refused at once
// because the requester is not attached or the queue is empty. Any other
// receive then walks the slot cells one per cycle up to the first matching
// message, or ends at the last queued message if none matches. Each result
// is shown with done high for exactly one cycle and must be taken then,
// since the receiver cannot stall the block.
module typed_message_queue_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [3:0]  queue_id,
  input  logic [15:0] requester_id,
  input  logic        create_flag,
  input  logic        exclusive_flag,
  input  logic        nowait_flag,
  input  logic        noerror_flag,
  input  logic [31:0] msg_type,
  input  logic [7:0]  msg_size,
  input  logic [63:0] payload,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  ret_value,
  output logic [30:0] rcv_type,
  output logic [63:0] rcv_payload,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmqe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ASCAN = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SSCAN = 4'b1000
  } state_t;

  state_t state;

  logic [11:0] max_queue_bytes;
  logic [4:0]  max_queue_messages;

  logic [UC_W-1:0]  user_count   [QUEUE_COUNT];
  logic [11:0]      queued_bytes [QUEUE_COUNT];
  logic [CNT_W-1:0] queued_count [QUEUE_COUNT];

  logic [1:0]  op_r;
  logic [3:0]  qid_r;
  logic [15:0] rid_r;
  logic        cf_r, ef_r, nw_r, ne_r;
  logic [31:0] sel_r;
  logic [7:0]  size_r;
  logic [63:0] body_r;

  logic [AIW-1:0] ka;
  logic [SIW-1:0] ks;
  logic           me_found, free_found;
  logic [AIW-1:0] me_idx, free_idx;

  logic [QIW-1:0]   qidx;
  logic [UC_W-1:0]  uc_cur;
  logic [11:0]      qb_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic [7:0]       lim8;
  logic             cnt_full, bytes_over, type_bad, size_bad, rule_fail, send_ok;
  logic             bad_queue_in, hit_now;
  logic [7:0]       ret_clip;

  att_ctrl_t  att_ctrl [ATTACH_PER_QUEUE];
  att_stat_t  att_stat [ATTACH_PER_QUEUE];
  slot_ctrl_t slot_ctrl [SLOTS_PER_QUEUE];
  slot_data_t slot_cur  [SLOTS_PER_QUEUE];
  slot_data_t slot_nbr  [SLOTS_PER_QUEUE];
  logic       slot_match [SLOTS_PER_QUEUE];
  slot_data_t new_data;
  slot_data_t hit_data;

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_MAX_BYTES: prdata = 32'(max_queue_bytes);
      REG_MAX_MSGS:  prdata = 32'(max_queue_messages);
      default:       prdata = 32'd0;
    endcase
  end

  assign bad_queue_in = 32'(queue_id) >= 32'(QUEUE_COUNT);
  assign qidx         = QIW'(qid_r);
  assign uc_cur       = user_count[qidx];
  assign qb_cur       = queued_bytes[qidx];
  assign cnt_cur      = queued_count[qidx];
  assign lim8         = (8'(max_queue_messages) < 8'(SLOTS_PER_QUEUE)) ?
                        8'(max_queue_messages) : 8'(SLOTS_PER_QUEUE);
  assign cnt_full     = (8'(cnt_cur) + 8'd1) > lim8;
  assign bytes_over   = (13'(qb_cur) + 13'(size_r)) > 13'(max_queue_bytes);
  assign type_bad     = sel_r[31] || (sel_r == 32'd0);
  assign size_bad     = size_r > 8'(MAX_MSG_BYTES);
  assign rule_fail    = (uc_cur == '0) ? !cf_r : ef_r;
  assign send_ok      = me_found && (uc_cur != '0) && !type_bad && !size_bad &&
                        !bytes_over && !cnt_full;
  assign hit_data     = slot_cur[ks];
  assign hit_now      = (state == S_SSCAN) && slot_match[ks];
  assign ret_clip     = (ne_r && size_r > 8'(MAX_MSG_BYTES)) ? 8'(MAX_MSG_BYTES) : size_r;
  assign new_data     = '{mtype: sel_r[30:0], size: size_r, body: body_r};

  always_comb begin
    for (int a = 0; a < ATTACH_PER_QUEUE; a++) begin
      att_ctrl[a].set = (state == S_EXEC) && (op_r == OP_ATTACH) && !me_found &&
                        !rule_fail && free_found && (free_idx == AIW'(a));
      att_ctrl[a].clr = (state == S_EXEC) && (op_r == OP_DETACH) && me_found &&
                        (me_idx == AIW'(a));
    end
    for (int s = 0; s < SLOTS_PER_QUEUE; s++) begin
      slot_ctrl[s].wr_new   = (state == S_EXEC) && (op_r == OP_SEND) && send_ok &&
                              (CNT_W'(s) == cnt_cur);
      slot_ctrl[s].wr_shift = hit_now && (SIW'(s) >= ks) &&
                              (CNT_W'(s) + CNT_W'(1) < cnt_cur);
    end
  end

  for (genvar a = 0; a < ATTACH_PER_QUEUE; a++) begin : g_att
    tmqe_att_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .qidx (qidx),
      .rid  (rid_r),
      .ctrl (att_ctrl[a]),
      .stat (att_stat[a])
    );
  end

  for (genvar s = 0; s < SLOTS_PER_QUEUE; s++) begin : g_slot
    if (s + 1 < SLOTS_PER_QUEUE) begin : g_nbr
      assign slot_nbr[s] = slot_cur[s+1];
    end else begin : g_last
      assign slot_nbr[s] = '0;
    end
    tmqe_slot_cell u_cell (
      .clk      (clk),
      .qidx     (qidx),
      .ctrl     (slot_ctrl[s]),
      .new_data (new_data),
      .nbr_data (slot_nbr[s]),
      .sel      (sel_r),
      .cur      (slot_cur[s]),
      .match    (slot_match[s])
    );
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= op;
      qid_r  <= queue_id;
      rid_r  <= requester_id;
      cf_r   <= create_flag;
      ef_r   <= exclusive_flag;
      nw_r   <= nowait_flag;
      ne_r   <= noerror_flag;
      sel_r  <= msg_type;
      size_r <= msg_size;
      body_r <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      done               <= 1'b0;
      max_queue_bytes    <= MAX_BYTES_RST;
      max_queue_messages <= MAX_MSGS_RST;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        user_count[i]   <= '0;
        queued_bytes[i] <= '0;
        queued_count[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_MAX_BYTES: max_queue_bytes <= pwdata[11:0];
          REG_MAX_MSGS:  max_queue_messages <= pwdata[4:0];
          default:       max_queue_bytes <= max_queue_bytes;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (bad_queue_in) begin
              done        <= 1'b1;
              status      <= ST_BAD_QUEUE;
              ret_value   <= '0;
              rcv_type    <= '0;
              rcv_payload <= '0;
            end else begin
              state      <= S_ASCAN;
              ka         <= '0;
              me_found   <= 1'b0;
              free_found <= 1'b0;
            end
          end
        end
        S_ASCAN: begin
          if (att_stat[ka].eq) begin
            me_found <= 1'b1;
            me_idx   <= ka;
          end
          if (att_stat[ka].free && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= ka;
          end
          if (ka == AIW'(ATTACH_PER_QUEUE - 1)) begin
            state <= S_EXEC;
          end else begin
            ka <= ka + AIW'(1);
          end
        end
        S_EXEC: begin
          done        <= 1'b1;
          state       <= S_IDLE;
          status      <= ST_OK;
          ret_value   <= '0;
          rcv_type    <= '0;
          rcv_payload <= '0;
          case (op_r)
            OP_ATTACH: begin
              if (me_found) begin
                status <= ST_ATTACH_STATE;
              end else if (rule_fail) begin
                status <= ST_CREATE_RULE;
              end else if (!free_found) begin
                status <= ST_TABLE_FULL;
              end else begin
                user_count[qidx] <= uc_cur + UC_W'(1);
                ret_value        <= 8'(qid_r);
              end
            end
            OP_DETACH: begin
              if (!me_found) begin
                status <= ST_ATTACH_STATE;
              end else begin
                user_count[qidx] <= uc_cur - UC_W'(1);
              end
            end
            OP_SEND: begin
              if (uc_cur == '0 || !me_found) begin
                status <= ST_ATTACH_STATE;
              end else if (type_bad || size_bad) begin
                status <= ST_REFUSED;
              end else if (bytes_over || cnt_full) begin
                status <= nw_r ? ST_REFUSED : ST_WOULD_BLOCK;
              end else begin
                queued_count[qidx] <= cnt_cur + CNT_W'(1);
                queued_bytes[qidx] <= qb_cur + 12'(size_r);
                ret_value          <= size_r;
              end
            end
            OP_RECEIVE: begin
              if (!me_found) begin
                status <= ST_ATTACH_STATE;
              end else if (cnt_cur == '0) begin
                status <= nw_r ? ST_REFUSED : ST_WOULD_BLOCK;
              end else begin
                done  <= 1'b0;
                state <= S_SSCAN;
                ks    <= '0;
              end
            end
            default: status <= ST_OK;
          endcase
        end
        S_SSCAN: begin
          if (slot_match[ks]) begin
            done               <= 1'b1;
            state              <= S_IDLE;
            status             <= ST_OK;
            ret_value          <= ret_clip;
            rcv_type           <= hit_data.mtype;
            rcv_payload        <= hit_data.body;
            queued_bytes[qidx] <= qb_cur - 12'(hit_data.size);
            queued_count[qidx] <= cnt_cur - CNT_W'(1);
          end else if (CNT_W'(ks) + CNT_W'(1) == cnt_cur) begin
            done        <= 1'b1;
            state       <= S_IDLE;
            status      <= nw_r ? ST_REFUSED : ST_WOULD_BLOCK;
            ret_value   <= '0;
            rcv_type    <= '0;
            rcv_payload <= '0;
          end else begin
            ks <= ks + SIW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("Sequencer state is not one-hot.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SSCAN |-> CNT_W'(ks) < cnt_cur)
    else $error("Slot scan ran past the queued messages.");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> ret_value == 8'd0 && rcv_type == 31'd0 &&
    rcv_payload == 64'd0)
    else $error("A failed request returned data.");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done && $past(state) == S_ASCAN |-> 1'b0)
    else $error("A result left the attach scan without an execute step.");

endmodule

// ----- tb/sv/tb_typed_message_queue_engine.sv -----
// Testbench for typed_message_queue_engine: directed and random queue traffic
// checked against an in-bench predictor kept by a small scoreboard class.
// Depends on tmqe_pkg and the typed_message_queue_engine RTL.
module tb_typed_message_queue_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import tmqe_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic [3:0]         qid;
    logic [15:0]        rid;
    logic               cf;
    logic               ef;
    logic               nw;
    logic               ne;
    logic signed [31:0] mtype;
    logic [7:0]         size;
    logic [63:0]        body;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  ret;
    logic [30:0] rtype;
    logic [63:0] rbody;
  } answer_t;

  typedef struct {
    logic [30:0] mtype;
    logic [7:0]  size;
    logic [63:0] body;
  } message_t;

  class queue_bank_scoreboard;
    int unsigned max_bytes = 32'(MAX_BYTES_RST);
    int unsigned max_msgs = 32'(MAX_MSGS_RST);
    message_t held[QUEUE_COUNT][$];
    bit att_valid[QUEUE_COUNT][ATTACH_PER_QUEUE];
    logic [15:0] att_id[QUEUE_COUNT][ATTACH_PER_QUEUE];
    int unsigned users[QUEUE_COUNT];
    int unsigned bytes_held[QUEUE_COUNT];
    answer_t pending[$];
    int errors;

    function int find_user(int q, logic [15:0] rid);
      for (int a = 0; a < ATTACH_PER_QUEUE; a++)
        if (att_valid[q][a] && att_id[q][a] == rid) return a;
      return -1;
    endfunction

    function int find_free(int q);
      for (int a = 0; a < ATTACH_PER_QUEUE; a++)
        if (!att_valid[q][a]) return a;
      return -1;
    endfunction

    function void note_request(request_t r);
      answer_t res;
      int q, me, fr, hit;
      int unsigned lim;
      longint sel, t;
      q = r.qid;
      sel = r.mtype;
      res = '{ST_OK, 8'd0, 31'd0, 64'd0};
      lim = (max_msgs < SLOTS_PER_QUEUE) ? max_msgs : SLOTS_PER_QUEUE;
      if (q >= QUEUE_COUNT) begin
        res.status = ST_BAD_QUEUE;
      end else begin
        me = find_user(q, r.rid);
        case (r.op)
          OP_ATTACH: begin
            fr = find_free(q);
            if (me >= 0) begin
              res.status = ST_ATTACH_STATE;
            end else if (users[q] == 0 ? !r.cf : r.ef) begin
              res.status = ST_CREATE_RULE;
            end else if (fr < 0) begin
              res.status = ST_TABLE_FULL;
            end else begin
              att_valid[q][fr] = 1'b1;
              att_id[q][fr] = r.rid;
              users[q]++;
              res.ret = 8'(q);
            end
          end
          OP_DETACH: begin
            if (me < 0) begin
              res.status = ST_ATTACH_STATE;
            end else begin
              att_valid[q][me] = 1'b0;
              users[q]--;
            end
          end
          OP_SEND: begin
            if (users[q] == 0 || me < 0) begin
              res.status = ST_ATTACH_STATE;
            end else if (sel <= 0 || r.size > MAX_MSG_BYTES) begin
              res.status = ST_REFUSED;
            end else if (bytes_held[q] + r.size > max_bytes || held[q].size() + 1 > lim) begin
              res.status = r.nw ? ST_REFUSED : ST_WOULD_BLOCK;
            end else begin
              held[q].push_back('{r.mtype[30:0], r.size, r.body});
              bytes_held[q] += r.size;
              res.ret = r.size;
            end
          end
          default: begin
            hit = -1;
            if (me < 0) begin
              res.status = ST_ATTACH_STATE;
            end else begin
              foreach (held[q][k]) begin
                t = held[q][k].mtype;
                if (hit < 0 && (sel == 0 || (sel > 0 && t == sel) || (sel < 0 && t <= -sel)))
                  hit = k;
              end
              if (hit < 0) begin
                res.status = r.nw ? ST_REFUSED : ST_WOULD_BLOCK;
              end else begin
                res.rtype = held[q][hit].mtype;
                res.rbody = held[q][hit].body;
                bytes_held[q] -= held[q][hit].size;
                held[q].delete(hit);
                res.ret = (r.ne && r.size > MAX_MSG_BYTES) ? 8'(MAX_MSG_BYTES) : r.size;
              end
            end
          end
        endcase
      end
      pending.push_back(res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report("unexpected result, status", 64'(got.status), 64'd0);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
        if (got.ret !== want.ret) report("ret_value", 64'(got.ret), 64'(want.ret));
        if (got.rtype !== want.rtype) report("rcv_type", 64'(got.rtype), 64'(want.rtype));
        if (got.rbody !== want.rbody) report("rcv_payload", got.rbody, want.rbody);
      end
    endtask
  endclass

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = '0;
  logic [3:0] queue_id = '0;
  logic [15:0] requester_id = '0;
  logic create_flag = 1'b0, exclusive_flag = 1'b0, nowait_flag = 1'b0, noerror_flag = 1'b0;
  logic [31:0] msg_type = '0;
  logic [7:0] msg_size = '0;
  logic [63:0] payload = '0;
  logic done;
  logic [2:0] status;
  logic [7:0] ret_value;
  logic [30:0] rcv_type;
  logic [63:0] rcv_payload;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  queue_bank_scoreboard sb = new();
  int cycles;
  bit quiet_phase;

  typed_message_queue_engine dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done) sb.check_answer('{status, ret_value, rcv_type, rcv_payload});

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task issue(request_t r);
    int g;
    @(posedge clk);
    start <= 1'b1;
    op <= r.op;
    queue_id <= r.qid;
    requester_id <= r.rid;
    create_flag <= r.cf;
    exclusive_flag <= r.ef;
    nowait_flag <= r.nw;
    noerror_flag <= r.ne;
    msg_type <= r.mtype;
    msg_size <= r.size;
    payload <= r.body;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    g = gap_len();
    start <= 1'b0;
    if (g > 0) begin
      repeat (g - 1) @(posedge clk);
    end
  endtask

  task drain();
    @(posedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MAX_BYTES) sb.max_bytes = 32'(value[11:0]);
    else sb.max_msgs = 32'(value[4:0]);
  endtask

  function request_t mk(logic [1:0] o, int q, logic [15:0] rid, bit cf, bit ef, bit nw,
                        bit ne, logic [31:0] t, logic [7:0] sz, logic [63:0] b);
    request_t r;
    r = '{o, q[3:0], rid, cf, ef, nw, ne, t, sz, b};
    return r;
  endfunction

  function request_t random_request();
    request_t r;
    int p;
    p = $urandom_range(0, 99);
    r.op = (p < 18) ? OP_ATTACH : (p < 26) ? OP_DETACH : (p < 63) ? OP_SEND : OP_RECEIVE;
    r.qid = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
    r.rid = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(0, 5)) : 16'($urandom);
    r.cf = $urandom_range(0, 9) < 7;
    r.ef = $urandom_range(0, 9) < 1;
    r.nw = 1'($urandom_range(0, 1));
    r.ne = 1'($urandom_range(0, 1));
    p = $urandom_range(0, 99);
    if (r.op == OP_RECEIVE)
      r.mtype = (p < 40) ? 0 : (p < 70) ? $urandom_range(1, 4) : (p < 90) ? -$urandom_range(1, 4)
                : $urandom;
    else
      r.mtype = (p < 90) ? $urandom_range(1, 4) : $urandom;
    r.size = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 120)) : 8'($urandom);
    r.body = {$urandom, $urandom};
    return r;
  endfunction

  initial begin
    int unsigned bytes_cfg[6] = '{2048, 0, 4095, 100, 300, 4095};
    int unsigned msgs_cfg[6] = '{16, 0, 31, 1, 4, 16};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    issue(mk(OP_ATTACH, 0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'd0, 0, 1, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'd0, 1, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'd0, 1, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'hFFFF, 1, 1, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'hFFFF, 0, 1, 0, 0, 0, 0, 0));
    issue(mk(OP_ATTACH, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_SEND, 0, 16'd7, 0, 0, 0, 0, 1, 1, 0));
    issue(mk(OP_SEND, 0, 16'd0, 0, 0, 0, 0, 0, 1, 0));
    issue(mk(OP_SEND, 0, 16'd0, 0, 0, 0, 0, 32'h8000_0000, 1, 0));
    issue(mk(OP_SEND, 0, 16'd0, 0, 0, 0, 0, 5, 129, 0));
    issue(mk(OP_SEND, 0, 16'd0, 0, 0, 0, 0, 7, 128, 64'h0123_4567_89AB_CDEF));
    issue(mk(OP_SEND, 0, 16'hFFFF, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, '1));
    issue(mk(OP_SEND, 0, 16'd0, 0, 0, 0, 0, 2, 0, 64'h5));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 1, 0, 3, 8, 0));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 0, 0, 3, 8, 0));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 0, 0, -3, 10, 0));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 0, 1, 32'h7FFF_FFFF, 255, 0));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 0, 1, 32'h8000_0000, 255, 0));
    issue(mk(OP_RECEIVE, 0, 16'd0, 0, 0, 0, 0, 0, 200, 0));
    issue(mk(OP_RECEIVE, 0, 16'd3, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_DETACH, 0, 16'd3, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 9; i++) issue(mk(OP_ATTACH, 15, 16'(i), 1, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_DETACH, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAX_BYTES, bytes_cfg[ph]);
      write_reg(REG_MAX_MSGS, msgs_cfg[ph]);
      for (int i = 0; i < 270; i++) begin
        if (i % 90 == 0) quiet_phase = ($urandom_range(0, 9) < 3);
        issue(random_request());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
